>>> hdl/gpis_pkg.sv
package gpis_pkg;

  // default number of grid states
  localparam int NUM_STATES_DEF = 16;

  // field widths
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 24;
  localparam int PROB_W  = 9;
  localparam int REW_W   = 16;
  localparam int DISC_W  = 9;
  localparam int EPS_W   = 16;
  localparam int ACT_W   = 2;
  localparam int NUM_ACT = 4;
  localparam int ROW_W   = PROB_W * NUM_ACT;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_REWARD = 2'd0,
    CFG_DISCOUNT    = 2'd1,
    CFG_EPSILON     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FUNC_EVAL    = 1'b0,
    FUNC_IMPROVE = 1'b1
  } func_e;

  // register reset values
  localparam logic [REW_W-1:0]  STEP_REWARD_RST = 16'hFF00;
  localparam logic [DISC_W-1:0] DISCOUNT_RST    = 9'd256;
  localparam logic [EPS_W-1:0]  EPSILON_RST     = 16'd128;

  // probability constants, Q1.8
  localparam logic [PROB_W-1:0] PROB_ONE     = 9'd256;
  localparam logic [PROB_W-1:0] PROB_ZERO    = 9'd0;
  localparam logic [PROB_W-1:0] PROB_QUARTER = 9'd64;

  // saturation limits
  localparam logic [VAL_W-1:0] VAL_POS_MAX = 24'h7FFFFF;
  localparam logic [VAL_W-1:0] VAL_NEG_MIN = 24'h800000;

  // sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_NBR_LAST  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_OLD_RD    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL1_FRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL1_LAST = 4'd4;
  localparam logic [STEP_W-1:0] STEP_T_FRST    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_T_LAST    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL2_FRST = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ACC_FRST  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ACC_LAST  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_IMP_WB    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_EVAL_SAT  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EVAL_WB   = 4'd11;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

endpackage

>>> hdl/gpis_ram.sv
module gpis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/gridworld_policy_iteration_step.sv
// evaluate and improve take one item at a time: busy holds off a new item until the result
// of the last one is strobed; evaluate runs on one shared 10x27 multiplier doing eight dependent
// products in turn, and both functions use the single read port of the value memory (four
// neighbors plus the old value)
// a new item is taken in the same cycle its predecessor's result is strobed out
// reset: control clears at once, then a clearing pass over all NUM_STATES entries with busy high
module gridworld_policy_iteration_step #(
  parameter int NUM_STATES = gpis_pkg::NUM_STATES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func_i,
  input  logic [gpis_pkg::IDX_W-1:0]     state_index_i,
  input  logic [gpis_pkg::IDX_W-1:0]     up_index_i,
  input  logic [gpis_pkg::IDX_W-1:0]     down_index_i,
  input  logic [gpis_pkg::IDX_W-1:0]     left_index_i,
  input  logic [gpis_pkg::IDX_W-1:0]     right_index_i,
  input  logic                           cfg_we_i,
  input  logic [gpis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gpis_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           done_o,
  output logic [gpis_pkg::VAL_W-1:0]     state_value_o,
  output logic [gpis_pkg::ACT_W-1:0]     policy_action_o,
  output logic                           changed_o
);

  import gpis_pkg::*;

  localparam int AW    = $clog2(NUM_STATES);
  localparam int MA_W  = DISC_W + 1;
  localparam int T_W   = 27;
  localparam int PR_W  = MA_W + T_W;
  localparam int ACC_W = PR_W + 2;

  // configuration registers
  logic [REW_W-1:0]  reward_q;
  logic [DISC_W-1:0] disc_q;
  logic [EPS_W-1:0]  eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reward_q <= STEP_REWARD_RST;
      disc_q   <= DISCOUNT_RST;
      eps_q    <= EPSILON_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_STEP_REWARD: reward_q <= cfg_wdata_i[REW_W-1:0];
        CFG_DISCOUNT:    disc_q   <= cfg_wdata_i[DISC_W-1:0];
        CFG_EPSILON:     eps_q    <= cfg_wdata_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              done_q, done_d;
  logic              accept;
  logic              run;
  logic              finish;

  // latched item
  logic              func_q;
  logic [IDX_W-1:0]  sidx_q;
  logic [IDX_W-1:0]  nbr_q [NUM_ACT];
  logic              state_ok_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign run    = (state_q == ST_RUN);
  assign finish = run && (((func_e'(func_q) == FUNC_EVAL) && (step_q == STEP_EVAL_WB)) ||
                          ((func_e'(func_q) == FUNC_IMPROVE) && (step_q == STEP_IMP_WB)));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    clr_d   = clr_q;
    done_d  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(NUM_STATES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        if (finish) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // capture the item at acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= func_i;
      sidx_q     <= state_index_i;
      nbr_q[0]   <= up_index_i;
      nbr_q[1]   <= down_index_i;
      nbr_q[2]   <= left_index_i;
      nbr_q[3]   <= right_index_i;
      state_ok_q <= (int'(state_index_i) < NUM_STATES);
    end
  end

  // value memory read address: neighbors first, then the state itself
  logic [IDX_W-1:0] rd_idx;
  logic             nbr_ok_d, nbr_ok_q;
  logic [AW-1:0]    val_raddr;

  always_comb begin
    rd_idx   = sidx_q;
    nbr_ok_d = 1'b0;
    if (step_q <= STEP_NBR_LAST) begin
      rd_idx   = nbr_q[step_q[1:0]];
      nbr_ok_d = (int'(rd_idx) < NUM_STATES);
    end
  end

  assign val_raddr = AW'(rd_idx);

  always_ff @(posedge clk_i) begin
    nbr_ok_q <= nbr_ok_d;
  end

  // memories
  logic              val_we, pol_we;
  logic [AW-1:0]     mem_waddr;
  logic [VAL_W-1:0]  val_wdata, val_rdata;
  logic [ROW_W-1:0]  pol_wdata, pol_rdata;
  logic [VAL_W-1:0]  res_q;
  logic [ACT_W-1:0]  best_q;

  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(sidx_q);
  assign val_we    = (state_q == ST_CLEAR) ||
                     (run && step_q == STEP_EVAL_WB && func_e'(func_q) == FUNC_EVAL &&
                      state_ok_q);
  assign pol_we    = (state_q == ST_CLEAR) ||
                     (run && step_q == STEP_IMP_WB && func_e'(func_q) == FUNC_IMPROVE &&
                      state_ok_q);
  assign val_wdata = (state_q == ST_CLEAR) ? '0 : res_q;

  // one-hot policy row for improve, uniform row while clearing
  always_comb begin
    for (int a = 0; a < NUM_ACT; a++) begin
      if (state_q == ST_CLEAR) begin
        pol_wdata[a*PROB_W +: PROB_W] = PROB_QUARTER;
      end else begin
        pol_wdata[a*PROB_W +: PROB_W] = (best_q == ACT_W'(a)) ? PROB_ONE : PROB_ZERO;
      end
    end
  end

  gpis_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_STATES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  gpis_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_STATES)
  ) u_pol_ram (
    .clk_i   (clk_i),
    .we_i    (pol_we),
    .waddr_i (mem_waddr),
    .wdata_i (pol_wdata),
    .raddr_i (AW'(sidx_q)),
    .rdata_o (pol_rdata)
  );

  // neighbor value, zero when the neighbor is off the grid
  logic signed [VAL_W-1:0] v_eff;
  assign v_eff = nbr_ok_q ? $signed(val_rdata) : '0;

  // probability select: action under compare or under second product
  logic               mul1_win;
  logic [STEP_W-1:0]  pidx_full;
  logic [ACT_W-1:0]   pidx;
  logic [PROB_W-1:0]  p_sel;

  assign mul1_win  = (step_q >= STEP_MUL1_FRST) && (step_q <= STEP_MUL1_LAST);
  assign pidx_full = mul1_win ? (step_q - STEP_MUL1_FRST) : (step_q - STEP_MUL2_FRST);
  assign pidx      = pidx_full[ACT_W-1:0];
  assign p_sel     = pol_rdata[pidx*PROB_W +: PROB_W];

  // shared multiplier: discount * value, then probability * term
  logic signed [MA_W-1:0] mul_a;
  logic signed [T_W-1:0]  mul_b;
  logic signed [PR_W-1:0] prod_d, prod_q;
  logic signed [T_W-1:0]  t_q [NUM_ACT];
  logic [STEP_W-1:0]      tw_full;
  logic [STEP_W-1:0]      tr_full;

  assign tw_full = step_q - STEP_T_FRST;
  assign tr_full = step_q - STEP_MUL2_FRST;

  always_comb begin
    if (mul1_win) begin
      mul_a = $signed({1'b0, disc_q});
      mul_b = T_W'(v_eff);
    end else begin
      mul_a = $signed({1'b0, p_sel});
      mul_b = t_q[tr_full[ACT_W-1:0]];
    end
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // per-action term: reward plus scaled discounted value
  always_ff @(posedge clk_i) begin
    if (run && step_q >= STEP_T_FRST && step_q <= STEP_T_LAST) begin
      t_q[tw_full[ACT_W-1:0]] <= T_W'(prod_q >>> 8) + T_W'($signed(reward_q));
    end
  end

  // accumulate weighted terms
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (run && step_q == STEP_ACC_FRST) begin
      acc_q <= ACC_W'(prod_q);
    end else if (run && step_q > STEP_ACC_FRST && step_q <= STEP_ACC_LAST) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // scale down and saturate to the value format
  logic signed [ACC_W-1:0] acc_sh;
  logic                    acc_fits;
  logic [VAL_W-1:0]        sat_val;

  assign acc_sh   = acc_q >>> 8;
  assign acc_fits = (&acc_sh[ACC_W-1:VAL_W-1]) || !(|acc_sh[ACC_W-1:VAL_W-1]);
  assign sat_val  = acc_fits ? acc_sh[VAL_W-1:0] :
                    (acc_sh[ACC_W-1] ? VAL_NEG_MIN : VAL_POS_MAX);

  logic [VAL_W-1:0] old_q;

  always_ff @(posedge clk_i) begin
    if (run && step_q == STEP_EVAL_SAT) begin
      res_q <= sat_val;
    end
    if (run && step_q == STEP_OLD_RD + 1'b1) begin
      old_q <= val_rdata;
    end
  end

  // change test against epsilon
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]        diff_abs;
  logic                  val_moved;

  assign diff      = $signed({res_q[VAL_W-1], res_q}) - $signed({old_q[VAL_W-1], old_q});
  assign diff_abs  = diff[VAL_W] ? (VAL_W + 1)'(0) - diff : diff;
  assign val_moved = diff_abs > (VAL_W + 1)'(eps_q);

  // running first-maximum search over neighbor values and policy entries
  logic signed [VAL_W-1:0] bv_q;
  logic [PROB_W-1:0]       bp_q;
  logic [ACT_W-1:0]        prev_q;

  always_ff @(posedge clk_i) begin
    if (run && step_q == STEP_MUL1_FRST) begin
      bv_q   <= v_eff;
      best_q <= '0;
      bp_q   <= p_sel;
      prev_q <= '0;
    end else if (run && mul1_win) begin
      if (v_eff > bv_q) begin
        bv_q   <= v_eff;
        best_q <= pidx;
      end
      if (p_sel > bp_q) begin
        bp_q   <= p_sel;
        prev_q <= pidx;
      end
    end
  end

  // result registers
  logic [VAL_W-1:0] out_val_q;
  logic [ACT_W-1:0] out_act_q;
  logic             out_chg_q;

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (func_e'(func_q) == FUNC_EVAL) begin
        out_val_q <= state_ok_q ? res_q : '0;
        out_act_q <= '0;
        out_chg_q <= state_ok_q && val_moved;
      end else begin
        out_val_q <= state_ok_q ? val_rdata : '0;
        out_act_q <= state_ok_q ? best_q : '0;
        out_chg_q <= state_ok_q && (prev_q != best_q);
      end
    end
  end

  assign done_o          = done_q;
  assign state_value_o   = out_val_q;
  assign policy_action_o = out_act_q;
  assign changed_o       = out_chg_q;

  // result strobe lasts one cycle and follows a finished run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_RUN) && !$past(done_o))
    else $error("result strobe without a finished run");

  // an accepted item starts the sequencer at its first step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("accepted item did not start the sequencer");

  // a state off the grid gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !state_ok_q |-> (state_value_o == '0) && (policy_action_o == '0) && !changed_o)
    else $error("off-grid state gave a nonzero result");

  // evaluate never reports an action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (func_e'(func_q) == FUNC_EVAL) |-> (policy_action_o == '0))
    else $error("evaluate result carries an action");

endmodule

>>> tb/tb_gridworld_policy_iteration_step.sv
`timescale 1ns / 100ps

module tb_gridworld_policy_iteration_step;
  import gpis_pkg::*;

  localparam int NSTATES = NUM_STATES_DEF;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DIR_ROWS = 12;
  localparam int MAX_PRINTS = 20;
  localparam longint VAL_HI = 64'sd8388607;
  localparam longint VAL_LO = -64'sd8388608;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // action codes on policy_action_o
  localparam logic [ACT_W-1:0] ACT_UP    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DOWN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd3;

  typedef struct packed {
    func_e            fn;
    logic [IDX_W-1:0] st;
    logic [IDX_W-1:0] up;
    logic [IDX_W-1:0] dn;
    logic [IDX_W-1:0] lf;
    logic [IDX_W-1:0] rt;
  } backup_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [ACT_W-1:0] act;
    logic             chg;
  } backup_res_t;

  typedef struct {
    backup_cmd_t cmd;
    bit          typed;
    backup_res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic func_i;
  logic [IDX_W-1:0] state_index_i;
  logic [IDX_W-1:0] up_index_i;
  logic [IDX_W-1:0] down_index_i;
  logic [IDX_W-1:0] left_index_i;
  logic [IDX_W-1:0] right_index_i;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic done_o;
  logic [VAL_W-1:0] state_value_o;
  logic [ACT_W-1:0] policy_action_o;
  logic changed_o;

  // mirror of the block's stores and registers
  logic signed [VAL_W-1:0] value_q [NSTATES];
  logic [PROB_W-1:0] policy_q [NSTATES*NUM_ACT];
  logic signed [REW_W-1:0] reward_q;
  logic [DISC_W-1:0] discount_q;
  logic [EPS_W-1:0] eps_q;

  backup_res_t expected_backups [$];

  int n_errors = 0;
  int n_results = 0;
  int n_eval = 0;
  int n_improve = 0;
  int n_changed = 0;
  int n_sat = 0;

  // directed rows; typed expectations assume reset state and reset registers
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{FUNC_EVAL,    4'd0,  4'd0,  4'd0,  4'd0,  4'd0},  1'b1, '{24'hFFFF00, ACT_UP,    1'b1}},
    '{'{FUNC_IMPROVE, 4'd1,  4'd0,  4'd1,  4'd2,  4'd3},  1'b1, '{24'h000000, ACT_DOWN,  1'b1}},
    '{'{FUNC_IMPROVE, 4'd1,  4'd0,  4'd1,  4'd2,  4'd3},  1'b1, '{24'h000000, ACT_DOWN,  1'b0}},
    '{'{FUNC_IMPROVE, 4'd2,  4'd5,  4'd5,  4'd5,  4'd5},  1'b1, '{24'h000000, ACT_UP,    1'b0}},
    '{'{FUNC_EVAL,    4'd1,  4'd6,  4'd0,  4'd7,  4'd8},  1'b1, '{24'hFFFE00, ACT_UP,    1'b1}},
    '{'{FUNC_IMPROVE, 4'd3,  4'd0,  4'd0,  4'd0,  4'd9},  1'b1, '{24'h000000, ACT_RIGHT, 1'b1}},
    '{'{FUNC_EVAL,    4'd15, 4'd15, 4'd15, 4'd15, 4'd15}, 1'b0, '0},
    '{'{FUNC_IMPROVE, 4'd15, 4'd15, 4'd14, 4'd11, 4'd15}, 1'b0, '0},
    '{'{FUNC_EVAL,    4'd0,  4'd0,  4'd4,  4'd0,  4'd1},  1'b0, '0},
    '{'{FUNC_EVAL,    4'd3,  4'd3,  4'd7,  4'd2,  4'd3},  1'b0, '0},
    '{'{FUNC_IMPROVE, 4'd14, 4'd10, 4'd14, 4'd13, 4'd15}, 1'b0, '0},
    '{'{FUNC_EVAL,    4'd10, 4'd6,  4'd14, 4'd9,  4'd11}, 1'b0, '0}
  };

  // per-phase register settings and sender idle rate
  int rew_set  [PHASES] = '{-256, -32768, 0, 32767, 0, -256};
  int disc_set [PHASES] = '{256, 511, 0, 511, 0, 230};
  int eps_set  [PHASES] = '{128, 65535, 0, 0, 0, 16};
  int idle_set [PHASES] = '{18, 18, 88, 88, 0, 0};

  gridworld_policy_iteration_step uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .state_index_i   (state_index_i),
    .up_index_i      (up_index_i),
    .down_index_i    (down_index_i),
    .left_index_i    (left_index_i),
    .right_index_i   (right_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .state_value_o   (state_value_o),
    .policy_action_o (policy_action_o),
    .changed_o       (changed_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_backups.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) $display("%0t ns mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  // one bellman backup on the mirrored stores
  function automatic backup_res_t bellman_backup(input backup_cmd_t c);
    backup_res_t r;
    longint nv [NUM_ACT];
    logic [IDX_W-1:0] nidx [NUM_ACT];
    logic [PROB_W-1:0] p [NUM_ACT];
    longint acc;
    longint t;
    longint fresh;
    longint diff;
    int prev;
    int best;
    r = '0;
    nidx[0] = c.up;
    nidx[1] = c.dn;
    nidx[2] = c.lf;
    nidx[3] = c.rt;
    for (int a = 0; a < NUM_ACT; a++) begin
      nv[a] = (nidx[a] < NSTATES) ? longint'(value_q[nidx[a]]) : 0;
      p[a] = policy_q[c.st*NUM_ACT + a];
    end
    if (c.st >= NSTATES) return r;
    if (c.fn == FUNC_EVAL) begin
      acc = 0;
      for (int a = 0; a < NUM_ACT; a++) begin
        t = longint'(reward_q) + ((longint'(discount_q) * nv[a]) >>> 8);
        acc += longint'(p[a]) * t;
      end
      fresh = acc >>> 8;
      if (fresh > VAL_HI) fresh = VAL_HI;
      else if (fresh < VAL_LO) fresh = VAL_LO;
      diff = fresh - longint'(value_q[c.st]);
      if (diff < 0) diff = -diff;
      r.chg = (diff > longint'(eps_q));
      value_q[c.st] = fresh[VAL_W-1:0];
      r.val = fresh[VAL_W-1:0];
    end else begin
      // first maximum wins on both sides
      prev = 0;
      best = 0;
      for (int a = 1; a < NUM_ACT; a++) begin
        if (p[a] > p[prev]) prev = a;
        if (nv[a] > nv[best]) best = a;
      end
      r.chg = (prev != best);
      for (int a = 0; a < NUM_ACT; a++)
        policy_q[c.st*NUM_ACT + a] = (a == best) ? PROB_ONE : PROB_ZERO;
      r.act = best[ACT_W-1:0];
      r.val = value_q[c.st];
    end
    return r;
  endfunction

  // present one item, predict at the accepting edge, then maybe idle
  task automatic send_item(input backup_cmd_t c, input bit typed, input backup_res_t want,
                           input int idle_pct);
    backup_res_t r;
    int gap;
    start <= 1'b1;
    func_i <= c.fn;
    state_index_i <= c.st;
    up_index_i <= c.up;
    down_index_i <= c.dn;
    left_index_i <= c.lf;
    right_index_i <= c.rt;
    do @(posedge clk_i); while (busy);
    r = bellman_backup(c);
    expected_backups.push_back(typed ? want : r);
    if (c.fn == FUNC_EVAL) n_eval++;
    else n_improve++;
    if (r.chg) n_changed++;
    if (r.val == VAL_POS_MAX || r.val == VAL_NEG_MIN) n_sat++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every outstanding result is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_backups.size() != 0);
  endtask

  // write all registers, plus the unused index which must change nothing
  task automatic program_regs(input logic [REW_W-1:0] rew, input logic [DISC_W-1:0] disc,
                              input logic [EPS_W-1:0] eps);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_STEP_REWARD;
    cfg_wdata_i <= rew;
    @(posedge clk_i);
    reward_q = rew;
    cfg_index_i <= CFG_DISCOUNT;
    cfg_wdata_i <= {7'($urandom), disc};
    @(posedge clk_i);
    discount_q = disc;
    cfg_index_i <= CFG_EPSILON;
    cfg_wdata_i <= eps;
    @(posedge clk_i);
    eps_q = eps;
    cfg_index_i <= CFG_SPARE_IDX;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    backup_res_t exp_r;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_backups.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, value %h", state_value_o));
      end else begin
        exp_r = expected_backups.pop_front();
        if (state_value_o !== exp_r.val)
          flag_mismatch($sformatf("state_value %h, expected %h", state_value_o, exp_r.val));
        if (policy_action_o !== exp_r.act)
          flag_mismatch($sformatf("policy_action %0d, expected %0d", policy_action_o,
                                  exp_r.act));
        if (changed_o !== exp_r.chg)
          flag_mismatch($sformatf("changed %b, expected %b", changed_o, exp_r.chg));
      end
    end
  end

  // stimulus
  initial begin
    backup_cmd_t c;
    logic [IDX_W-1:0] s;
    int idle;
    rst_ni <= 1'b0;
    start <= 1'b0;
    func_i <= 1'b0;
    state_index_i <= '0;
    up_index_i <= '0;
    down_index_i <= '0;
    left_index_i <= '0;
    right_index_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    for (int i = 0; i < NSTATES; i++) value_q[i] = '0;
    for (int i = 0; i < NSTATES*NUM_ACT; i++) policy_q[i] = PROB_QUARTER;
    reward_q = STEP_REWARD_RST;
    discount_q = DISCOUNT_RST;
    eps_q = EPSILON_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset
    do @(posedge clk_i); while (busy);

    // directed rows under reset registers
    foreach (dir_tab[i]) send_item(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 4)
        program_regs(16'($urandom), 9'($urandom_range(0, 511)), 16'($urandom_range(0, 1023)));
      else
        program_regs(16'(rew_set[ph]), 9'(disc_set[ph]), 16'(eps_set[ph]));
      idle = idle_set[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        s = 4'($urandom);
        c.fn = ($urandom_range(0, 99) < 35) ? FUNC_IMPROVE : FUNC_EVAL;
        c.st = s;
        if ($urandom_range(0, 99) < 70) begin
          // 4x4 grid moves, walls bounce back to the same state
          c.up = (s[3:2] != 2'd0) ? s - 4'd4 : s;
          c.dn = (s[3:2] != 2'd3) ? s + 4'd4 : s;
          c.lf = (s[1:0] != 2'd0) ? s - 4'd1 : s;
          c.rt = (s[1:0] != 2'd3) ? s + 4'd1 : s;
        end else begin
          c.up = 4'($urandom);
          c.dn = 4'($urandom);
          c.lf = 4'($urandom);
          c.rt = 4'($urandom);
        end
        send_item(c, 1'b0, '0, idle);
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (expected_backups.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_backups.size()));
    $display("covered %0d items (%0d evaluate, %0d improve) over %0d register settings",
             n_eval + n_improve, n_eval, n_improve, PHASES + 1);
    $display("%0d results seen, %0d flagged changed, %0d at a saturation limit",
             n_results, n_changed, n_sat);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/gpis_pkg.sv
hdl/gpis_ram.sv
hdl/gridworld_policy_iteration_step.sv
tb/tb_gridworld_policy_iteration_step.sv
